/* design/dual_current_two_stage_averager_unit_assert.svh */
// ----------------------------------------------------------------------------
// dual current averager assertion macros
// concurrent checks that compile away when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef DUAL_CURRENT_TWO_STAGE_AVERAGER_UNIT_ASSERT_SVH
`define DUAL_CURRENT_TWO_STAGE_AVERAGER_UNIT_ASSERT_SVH

`ifndef SYNTH
`define DCAVG_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("dcavg assertion failed");
`define DCAVG_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dcavg assertion failed");
`else
`define DCAVG_ASSERT(name, clk, rst, prop)
`define DCAVG_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

/* design/dcavg_pkg.sv */
// ----------------------------------------------------------------------------
// dcavg_pkg
// shared types and sizing for the dual current averager
// ----------------------------------------------------------------------------
package dcavg_pkg;

  localparam int BLOCK_SAMPLES = 8;
  localparam int RING_BLOCKS   = 8;

  localparam int SAMPLE_W = 10;
  localparam int GAIN_W   = 24;
  localparam int OFFSET_W = 16;
  localparam int CURR_W   = 16;
  localparam int CFG_W    = 24;

  localparam int CNT_W   = (BLOCK_SAMPLES > 1) ? $clog2(BLOCK_SAMPLES) : 1;
  localparam int PTR_W   = (RING_BLOCKS > 1) ? $clog2(RING_BLOCKS) : 1;
  localparam int BSUM_W  = SAMPLE_W + $clog2(BLOCK_SAMPLES);
  localparam int TOTAL_W = BSUM_W + $clog2(RING_BLOCKS);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  localparam logic [GAIN_W-1:0]   GAIN_RESET   = GAIN_W'(5005);
  localparam logic [OFFSET_W-1:0] OFFSET_RESET = OFFSET_W'(2500);

  // register indexes of the config port
  localparam logic REG_GAIN   = 1'b0;
  localparam logic REG_OFFSET = 1'b1;

  typedef struct packed {
    logic [SAMPLE_W-1:0] right_sample;
    logic [SAMPLE_W-1:0] left_sample;
  } in_t;

  typedef struct packed {
    logic signed [CURR_W-1:0] current_right_ma;
    logic signed [CURR_W-1:0] current_left_ma;
    logic                     ring_updated;
  } out_t;

  // totals handed from the accumulator to the scaler
  typedef struct packed {
    logic [TOTAL_W-1:0] total_right;
    logic [TOTAL_W-1:0] total_left;
    logic               updated;
  } mid_t;

endpackage

/* design/dcavg_front.sv */
// ----------------------------------------------------------------------------
// dcavg_front
// block sums, ring of block sums and running totals per channel
// ----------------------------------------------------------------------------
`include "dual_current_two_stage_averager_unit_assert.svh"

module dcavg_front
  import dcavg_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  in_t  samples,
  output logic q_push,
  output mid_t q_item,
  input  logic q_full
);

  logic [BSUM_W-1:0]  block_sum_right;
  logic [BSUM_W-1:0]  block_sum_left;
  logic [CNT_W-1:0]   sample_count;
  logic [BSUM_W-1:0]  ring_right [RING_BLOCKS];
  logic [BSUM_W-1:0]  ring_left  [RING_BLOCKS];
  logic [PTR_W-1:0]   ring_pointer;
  logic [TOTAL_W-1:0] total_right;
  logic [TOTAL_W-1:0] total_left;

  logic               accept;
  logic               block_done;
  logic [BSUM_W-1:0]  sum_right_next;
  logic [BSUM_W-1:0]  sum_left_next;
  logic [TOTAL_W-1:0] total_right_next;
  logic [TOTAL_W-1:0] total_left_next;

  assign full       = q_full;
  assign accept     = push && !q_full;
  assign block_done = (sample_count == CNT_W'(BLOCK_SAMPLES - 1));

  assign sum_right_next = block_sum_right + BSUM_W'(samples.right_sample);
  assign sum_left_next  = block_sum_left + BSUM_W'(samples.left_sample);

  // new block sum in, oldest slot out
  assign total_right_next = total_right - TOTAL_W'(ring_right[ring_pointer])
                            + TOTAL_W'(sum_right_next);
  assign total_left_next  = total_left - TOTAL_W'(ring_left[ring_pointer])
                            + TOTAL_W'(sum_left_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      block_sum_right <= '0;
      block_sum_left  <= '0;
      sample_count    <= '0;
      ring_pointer    <= '0;
      total_right     <= '0;
      total_left      <= '0;
      for (int i = 0; i < RING_BLOCKS; i++) begin
        ring_right[i] <= '0;
        ring_left[i]  <= '0;
      end
    end else if (accept) begin
      if (block_done) begin
        block_sum_right          <= '0;
        block_sum_left           <= '0;
        sample_count             <= '0;
        total_right              <= total_right_next;
        total_left               <= total_left_next;
        ring_right[ring_pointer] <= sum_right_next;
        ring_left[ring_pointer]  <= sum_left_next;
        if (ring_pointer == PTR_W'(RING_BLOCKS - 1)) begin
          ring_pointer <= '0;
        end else begin
          ring_pointer <= ring_pointer + 1'b1;
        end
      end else begin
        block_sum_right <= sum_right_next;
        block_sum_left  <= sum_left_next;
        sample_count    <= sample_count + 1'b1;
      end
    end
  end

  always_comb begin
    q_push = accept;
    if (block_done) begin
      q_item.total_right = total_right_next;
      q_item.total_left  = total_left_next;
      q_item.updated     = 1'b1;
    end else begin
      q_item.total_right = total_right;
      q_item.total_left  = total_left;
      q_item.updated     = 1'b0;
    end
  end

  `DCAVG_ASSERT(a_ptr_range, clk, rst, ring_pointer <= PTR_W'(RING_BLOCKS - 1))
  `DCAVG_ASSERT(a_cnt_range, clk, rst, sample_count <= CNT_W'(BLOCK_SAMPLES - 1))
  `DCAVG_ASSERT_NEXT(a_block_clear, clk, rst, accept && block_done, sample_count == '0)
  `DCAVG_ASSERT_NEXT(a_hold_stalled, clk, rst, !accept, $stable(total_right))

endmodule

/* design/dcavg_queue.sv */
// ----------------------------------------------------------------------------
// dcavg_queue
// short queue of running totals between accumulator and scaler
// ----------------------------------------------------------------------------
module dcavg_queue
  import dcavg_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  mid_t item_in,
  output logic full,
  input  logic pop,
  output mid_t item_out,
  output logic empty
);

  mid_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign full     = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign item_out = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* design/dcavg_back.sv */
// ----------------------------------------------------------------------------
// dcavg_back
// scales totals to mA: multiply stage, then shift, offset and saturate
// ----------------------------------------------------------------------------
`include "dual_current_two_stage_averager_unit_assert.svh"

module dcavg_back
  import dcavg_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  output logic                q_pop,
  input  mid_t                q_item,
  input  logic [GAIN_W-1:0]   gain_q16,
  input  logic [OFFSET_W-1:0] offset_ma,
  input  logic                pop,
  output logic                empty,
  output out_t                result
);

  localparam int PROD_W = TOTAL_W + GAIN_W;
  localparam int SCL_W  = PROD_W - 16;
  localparam int DIFF_W = SCL_W + 1;

  logic              s1_valid;
  logic              s1_updated;
  logic [PROD_W-1:0] s1_prod_right;
  logic [PROD_W-1:0] s1_prod_left;

  out_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_pop;
  logic [QCNT_W:0]   booked;
  out_t              scaled;

  function automatic logic signed [CURR_W-1:0] to_ma(logic [PROD_W-1:0] prod,
                                                     logic [OFFSET_W-1:0] offs);
    logic signed [DIFF_W-1:0]  diff;
    logic [DIFF_W-CURR_W:0]    hi;
    logic signed [CURR_W-1:0]  res;
    diff = $signed({1'b0, prod[PROD_W-1:16]}) - $signed(DIFF_W'(offs));
    hi   = diff[DIFF_W-1:CURR_W-1];
    if (hi == '0 || hi == '1) begin
      res = diff[CURR_W-1:0];
    end else if (diff[DIFF_W-1]) begin
      res = {1'b1, {(CURR_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(CURR_W-1){1'b1}}};
    end
    return res;
  endfunction

  // take a total only when the result queue has room for everything in flight
  assign booked = (QCNT_W+1)'(count) + (QCNT_W+1)'(s1_valid);
  assign q_pop  = !q_empty && (booked < (QCNT_W+1)'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_prod_right <= PROD_W'(q_item.total_right) * PROD_W'(gain_q16);
      s1_prod_left  <= PROD_W'(q_item.total_left) * PROD_W'(gain_q16);
      s1_updated    <= q_item.updated;
    end
  end

  always_comb begin
    scaled.current_right_ma = to_ma(s1_prod_right, offset_ma);
    scaled.current_left_ma  = to_ma(s1_prod_left, offset_ma);
    scaled.ring_updated     = s1_updated;
  end

  assign empty  = (count == '0);
  assign do_pop = pop && !empty;
  assign result = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      slots[wr_ptr] <= scaled;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      count    <= '0;
    end else begin
      s1_valid <= q_pop;
      if (s1_valid) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({s1_valid, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `DCAVG_ASSERT(a_no_overflow, clk, rst, !(s1_valid && count == QCNT_W'(QUEUE_DEPTH)))
  `DCAVG_ASSERT(a_count_range, clk, rst, count <= QCNT_W'(QUEUE_DEPTH))
  `DCAVG_ASSERT_NEXT(a_issue_lands, clk, rst, q_pop, s1_valid)

endmodule

/* design/dual_current_two_stage_averager_unit.sv */
// a result goes through the total queue, the multiply register and the result queue
// throughput: one pair per cycle unless full, one result per cycle while pop is held
// full rises only when the total queue backs up behind a stalled result side
// reset (synchronous, rst high) clears block sums, rings, totals and both queues
// reset loads gain_q16 = 5005 and offset_ma = 2500
// ----------------------------------------------------------------------------
// dual_current_two_stage_averager_unit
// two-stage moving average of two motor current channels, scaled to mA
// ----------------------------------------------------------------------------
module dual_current_two_stage_averager_unit
  import dcavg_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  in_t              samples,
  output logic             empty,
  input  logic             pop,
  output out_t             result,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  logic [GAIN_W-1:0]   gain_q16;
  logic [OFFSET_W-1:0] offset_ma;

  logic f_push;
  mid_t f_item;
  logic q_full;
  logic q_empty;
  logic q_pop;
  mid_t q_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_q16  <= GAIN_RESET;
      offset_ma <= OFFSET_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GAIN:   gain_q16  <= cfg_data[GAIN_W-1:0];
        REG_OFFSET: offset_ma <= cfg_data[OFFSET_W-1:0];
        default:    gain_q16  <= gain_q16;
      endcase
    end
  end

  dcavg_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .samples (samples),
    .q_push  (f_push),
    .q_item  (f_item),
    .q_full  (q_full)
  );

  dcavg_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (f_push),
    .item_in  (f_item),
    .full     (q_full),
    .pop      (q_pop),
    .item_out (q_item),
    .empty    (q_empty)
  );

  dcavg_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_item    (q_item),
    .gain_q16  (gain_q16),
    .offset_ma (offset_ma),
    .pop       (pop),
    .empty     (empty),
    .result    (result)
  );

endmodule
